### hdl/brm_pkg.sv
// Shared types and constants for the busy ratio meter.
package brm_pkg;

    // Event codes carried in the op field.
    localparam logic [1:0] OP_BUSY  = 2'd0;
    localparam logic [1:0] OP_IDLE  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam int unsigned ACC_W     = 32;   // accumulator width
    localparam int unsigned STAMP_W   = 32;   // stamp port width
    localparam int unsigned PCT_W     = 7;    // percentage width
    localparam int unsigned THR_W     = 8;    // threshold width
    localparam int unsigned NUM_W     = ACC_W + PCT_W;  // busy * 100
    localparam int unsigned TOT_W     = ACC_W + 1;      // busy + idle
    localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ACC  = 7'b0000010,
        S_SAT  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

endpackage

### hdl/busy_ratio_meter.sv
// Busy ratio meter top level: serial tick accumulation and percentage divide.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  in       | in_valid / in_stall    | op[1:0], stamp[31:0]
//  out      | out_valid / out_stall  | usage_percent[6:0], led_level
//  cfg      | cfg_wr_en (no wait)    | cfg_wr_data[7:0] = usage threshold
//
// One word at a time: the input stalls from accept until its result is loaded.
// With L = max(TIMER_WIDTH, 32), every op but the unused one runs the
// bit-serial subtract/add loop over L bits; the close adds a 7-step restoring
// divide. Each result is one word.
// rst_n asynchronously clears the control, threshold and accumulator state; indicator resets to 1.
// A stalled result holds in the output register; the next word's result
// waits in S_OUT until that register drains.
module busy_ratio_meter #(
    parameter int unsigned TIMER_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [brm_pkg::THR_W-1:0]     cfg_wr_data,
    // event input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [brm_pkg::STAMP_W-1:0]   stamp,
    // result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brm_pkg::PCT_W-1:0]     usage_percent,
    output logic                          led_level
);
    import brm_pkg::*;

    // Serial loop length: covers both the timer difference and the accumulator.
    localparam int unsigned LOOP_LEN = (TIMER_WIDTH > ACC_W) ? TIMER_WIDTH : ACC_W;
    localparam int unsigned CNT_W    = $clog2(LOOP_LEN);
    localparam int unsigned WIDE_W   = (TIMER_WIDTH > STAMP_W) ? TIMER_WIDTH : STAMP_W;
    localparam logic [CNT_W:0] TW_LIM   = (CNT_W+1)'(TIMER_WIDTH);
    localparam logic [CNT_W:0] ACC_LIM  = (CNT_W+1)'(ACC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOOP_LEN - 1);
    localparam logic [2:0] DIV_LAST = 3'(PCT_W - 1);

    state_t                 state_reg, state_next;
    logic [1:0]             op_reg;
    logic [THR_W-1:0]       thr_reg;
    logic                   busy_mode_reg;
    logic [TIMER_WIDTH-1:0] last_reg;      // doubles as a shift line during the loop
    logic [TIMER_WIDTH-1:0] cur_sh_reg;
    logic [ACC_W-1:0]       busy_reg;
    logic [ACC_W-1:0]       idle_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   borrow_reg;
    logic                   carry_reg;
    logic                   ovf_reg;
    logic [NUM_W-1:0]       rem_reg;
    logic [NUM_W-1:0]       dv_reg;
    logic [PCT_W-1:0]       q_reg;
    logic [2:0]             div_cnt_reg;
    logic                   zero_reg;
    logic [PCT_W-1:0]       usage_value_reg;
    logic                   indicator_reg;
    logic                   out_valid_reg;
    logic [PCT_W-1:0]       out_usage_reg;
    logic                   out_led_reg;

    logic                   in_take;
    logic                   out_take;
    logic                   out_load;
    logic [WIDE_W-1:0]      stamp_wide;
    logic                   in_tw;
    logic                   in_acc;
    logic                   c_bit, l_bit, d_bit, a_bit, s_bit;
    logic                   borrow_next, carry_next;
    logic [ACC_W-1:0]       acc_sel;
    logic                   sat;
    logic [TOT_W-1:0]       total;
    logic                   ge;
    logic [PCT_W-1:0]       usage_new;

    assign in_stall      = (state_reg != S_IDLE);
    assign in_take       = in_valid && !in_stall;
    assign out_take      = out_valid_reg && !out_stall;
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign out_valid     = out_valid_reg;
    assign usage_percent = out_usage_reg;
    assign led_level     = out_led_reg;

    assign stamp_wide = WIDE_W'(stamp);

    // One bit per cycle: d = cur - last (mod 2^TW), acc = acc + d.
    assign in_tw       = ({1'b0, cnt_reg} < TW_LIM);
    assign in_acc      = ({1'b0, cnt_reg} < ACC_LIM);
    assign c_bit       = cur_sh_reg[0];
    assign l_bit       = last_reg[0];
    assign d_bit       = in_tw && (c_bit ^ l_bit ^ borrow_reg);
    assign borrow_next = (~c_bit & l_bit) | (~(c_bit ^ l_bit) & borrow_reg);
    assign acc_sel     = busy_mode_reg ? busy_reg : idle_reg;
    assign a_bit       = acc_sel[0];
    assign s_bit       = a_bit ^ d_bit ^ carry_reg;
    assign carry_next  = (a_bit & d_bit) | (a_bit & carry_reg) | (d_bit & carry_reg);
    assign sat         = carry_reg | ovf_reg;

    assign total     = TOT_W'(busy_reg) + TOT_W'(idle_reg);
    assign ge        = (rem_reg >= dv_reg);
    assign usage_new = zero_reg ? '0 : q_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                    state_next = (op == OP_NONE) ? S_OUT : S_ACC;
            end
            S_ACC:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = S_SAT;
            end
            S_SAT:   state_next = (op_reg == OP_CLOSE) ? S_MUL : S_OUT;
            S_MUL:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_FIN;
            end
            S_FIN:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            thr_reg         <= '0;
            busy_mode_reg   <= 1'b0;
            last_reg        <= '0;
            busy_reg        <= '0;
            idle_reg        <= '0;
            usage_value_reg <= '0;
            indicator_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                thr_reg       <= cfg_wr_data;
                indicator_reg <= 1'b1;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                end
                S_ACC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (in_tw)
                        last_reg <= {c_bit, last_reg[TIMER_WIDTH-1:1]};
                    if (in_acc)
                    begin
                        if (busy_mode_reg)
                            busy_reg <= {s_bit, busy_reg[ACC_W-1:1]};
                        else
                            idle_reg <= {s_bit, idle_reg[ACC_W-1:1]};
                    end
                end
                S_SAT:
                begin
                    if (sat)
                    begin
                        if (busy_mode_reg)
                            busy_reg <= '1;
                        else
                            idle_reg <= '1;
                    end
                    if (op_reg == OP_BUSY)
                        busy_mode_reg <= 1'b1;
                    else if (op_reg == OP_IDLE)
                        busy_mode_reg <= 1'b0;
                end
                S_MUL:
                begin
                    div_cnt_reg <= '0;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                S_FIN:
                begin
                    usage_value_reg <= usage_new;
                    busy_reg        <= '0;
                    idle_reg        <= '0;
                    if (thr_reg != '0)
                        indicator_reg <= !(thr_reg < THR_W'(usage_new));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath shift lines and divider; no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= op;
            cur_sh_reg <= stamp_wide[TIMER_WIDTH-1:0];
            borrow_reg <= 1'b0;
            carry_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (state_reg == S_ACC)
        begin
            cur_sh_reg <= cur_sh_reg >> 1;
            if (in_tw)
                borrow_reg <= borrow_next;
            if (in_acc)
                carry_reg <= carry_next;
            else
                ovf_reg <= ovf_reg | d_bit;
        end

        if (state_reg == S_MUL)
        begin
            rem_reg  <= NUM_W'(busy_reg) * NUM_W'(PERCENT_SCALE);
            dv_reg   <= {total, (PCT_W-1)'(0)};
            zero_reg <= (total == '0);
        end
        else if (state_reg == S_DIV)
        begin
            if (ge)
                rem_reg <= rem_reg - dv_reg;
            dv_reg <= dv_reg >> 1;
            q_reg  <= {q_reg[PCT_W-2:0], ge};
        end

        if (out_load)
        begin
            out_usage_reg <= usage_value_reg;
            out_led_reg   <= indicator_reg;
        end
    end

    // A result never claims more than one hundred percent.
    a_usage_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (usage_percent <= PCT_W'(100)))
        else $error("usage_percent above 100");

    // An accepted word blocks the input for at least the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("second word accepted while one is in flight");

    // Closing a window leaves both accumulators empty.
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (busy_reg == '0 && idle_reg == '0))
        else $error("accumulators not cleared on close");

    // The serial loop counter stays inside the loop length.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> ({1'b0, cnt_reg} < (CNT_W+1)'(LOOP_LEN)))
        else $error("serial counter out of range");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the busy ratio meter: directed edges, threshold levels, random traffic.
`timescale 1ns / 1ps

module tb;
    import brm_pkg::*;

    // Run limits, in clock cycles.
    localparam int unsigned SETTLE_CYCLES  = 60;    // quiet time after the last expected word
    localparam int unsigned HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no word accepted

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [THR_W-1:0]     cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [1:0]           op          = OP_NONE;
    logic [STAMP_W-1:0]   stamp       = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [PCT_W-1:0]     usage_percent;
    logic                 led_level;

    busy_ratio_meter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .stamp         (stamp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .usage_percent (usage_percent),
        .led_level     (led_level)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One result word: the reading the meter should report.
    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic             led;
    } reading_t;

    reading_t pending_readings[$];   // expected result words, oldest first

    // Shadow copy of the meter state, advanced once per accepted input word.
    logic               in_busy_mode = 1'b0;
    logic [STAMP_W-1:0] prev_stamp   = '0;
    logic [ACC_W-1:0]   busy_acc     = '0;
    logic [ACC_W-1:0]   idle_acc     = '0;
    logic [PCT_W-1:0]   last_pct     = '0;
    logic               led_now      = 1'b1;
    logic [THR_W-1:0]   thr_now      = '0;

    // Traffic shaping knobs, percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long hold-off handshake between the test sequence and the stall process.
    int unsigned hold_req  = 0;
    int unsigned hold_ack  = 0;
    int unsigned hold_left = 0;

    logic [STAMP_W-1:0] stim_stamp  = '0;   // running timer seen by random traffic
    int unsigned        error_count = 0;
    int unsigned        quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Predictor: account the elapsed ticks to the current mode, then act
    // on the op. Accumulators clamp at all ones; op 3 leaves state alone.
    // ------------------------------------------------------------------
    task automatic predict_event(input logic [1:0] ev, input logic [STAMP_W-1:0] ts);
        logic [STAMP_W-1:0] delta;
        logic [ACC_W:0]     sum;
        logic [TOT_W-1:0]   total;
        longint unsigned    scaled;
        reading_t           r;
        if (ev != OP_NONE)
        begin
            // Timer is 32 bits wide, so plain subtraction wraps correctly.
            delta = ts - prev_stamp;
            prev_stamp = ts;
            if (in_busy_mode)
            begin
                sum = {1'b0, busy_acc} + delta;
                busy_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            end
            else
            begin
                sum = {1'b0, idle_acc} + delta;
                idle_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            end
            if (ev == OP_BUSY)
                in_busy_mode = 1'b1;
            else if (ev == OP_IDLE)
                in_busy_mode = 1'b0;
            else
            begin
                total = {1'b0, busy_acc} + idle_acc;
                if (total == 0)
                    last_pct = '0;   // empty window
                else
                begin
                    scaled = busy_acc;
                    scaled = scaled * 100;
                    last_pct = PCT_W'(scaled / total);
                end
                busy_acc = '0;
                idle_acc = '0;
                // Zero threshold: indicator keeps whatever level it has.
                if (thr_now != 0)
                    led_now = (last_pct > thr_now) ? 1'b0 : 1'b1;
            end
        end
        r.pct = last_pct;
        r.led = led_now;
        pending_readings.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Send one input word. Called right after an edge. Valid drops only
    // when a gap is taken, so it is never lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [1:0] ev, input logic [STAMP_W-1:0] ts);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        op       <= ev;
        stamp    <= ts;
        // Values read here are the ones from before the edge.
        do
            @(posedge clk);
        while (in_stall);
        predict_event(ev, ts);
    endtask

    // Stop sending and wait for every expected word, then let the block
    // go quiet before any register write.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Threshold write: also forces the indicator back to 1.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        thr_now = value;
        led_now = 1'b1;
        @(posedge clk);
    endtask

    // Random traffic: mostly a timer that moves forward by small steps, with
    // zero-length intervals, arbitrary jumps and near-full wraps mixed in.
    task automatic send_random_words(input int unsigned count);
        logic [1:0]         ev;
        logic [STAMP_W-1:0] ts;
        int unsigned        pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                ev = OP_BUSY;
            else if (pick < 76)
                ev = OP_IDLE;
            else if (pick < 94)
                ev = OP_CLOSE;
            else
                ev = OP_NONE;
            pick = $urandom_range(99);
            if (pick < 72)
                ts = stim_stamp + $urandom_range(2000);
            else if (pick < 82)
                ts = stim_stamp;
            else if (pick < 94)
                ts = $urandom();
            else
                ts = stim_stamp - $urandom_range(50, 1);   // wraps: huge delta
            if (ev != OP_NONE)
                stim_stamp = ts;
            send_word(ev, ts);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Unused op, empty window, plain ratio, timer wrap and saturation.
    task automatic test_directed_edges();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(OP_NONE,  32'hFFFF_FFFF);   // ignored, reset reading
        send_word(OP_CLOSE, 32'h0000_0000);   // nothing counted yet
        send_word(OP_BUSY,  32'd100);
        send_word(OP_IDLE,  32'd400);
        send_word(OP_CLOSE, 32'd400);         // 300 busy / 100 idle
        send_word(OP_BUSY,  32'hFFFF_FFF0);
        send_word(OP_IDLE,  32'h0000_0010);   // busy span crosses the wrap
        send_word(OP_CLOSE, 32'h0000_0010);
        // Drive both accumulators into saturation with full-range deltas.
        send_word(OP_BUSY,  32'h0000_0000);
        send_word(OP_BUSY,  32'hFFFF_FFFF);
        send_word(OP_BUSY,  32'hFFFF_FFFE);
        send_word(OP_IDLE,  32'hFFFF_FFFD);
        send_word(OP_IDLE,  32'hFFFF_FFFC);
        send_word(OP_IDLE,  32'hFFFF_FFFB);
        send_word(OP_CLOSE, 32'hFFFF_FFFB);   // both clamped: 50 percent
        settle();
    endtask

    // Indicator against thresholds at and around the percent range.
    task automatic test_threshold_levels();
        write_threshold(8'd99);
        send_word(OP_CLOSE, 32'd5000);        // flush leftover window
        send_word(OP_BUSY,  32'd5000);
        send_word(OP_CLOSE, 32'd6000);        // 100 > 99: led low
        settle();
        write_threshold(8'd100);
        send_word(OP_CLOSE, 32'd7000);        // 100 is not above 100
        settle();
        write_threshold(8'd1);
        send_word(OP_IDLE,  32'd7000);
        send_word(OP_BUSY,  32'd7990);
        send_word(OP_CLOSE, 32'd8000);        // 1 percent, not above 1
        settle();
        write_threshold(8'd255);
        send_word(OP_CLOSE, 32'd9000);
        settle();
        write_threshold(8'd0);
        send_word(OP_CLOSE, 32'd9500);        // disabled: level kept
        settle();
        stim_stamp = 32'd9500;
    endtask

    task automatic test_random_back_to_back();
        write_threshold(8'd50);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_words(110);
        settle();
    endtask

    task automatic test_random_sender_gaps();
        write_threshold(8'd0);
        send_idle_pct  = 79;
        recv_stall_pct = 0;
        send_random_words(90);
        settle();
    endtask

    task automatic test_random_receiver_stalls();
        write_threshold(8'd255);
        send_idle_pct  = 0;
        recv_stall_pct = 79;
        send_random_words(90);
        settle();
    endtask

    task automatic test_random_both_gaps();
        write_threshold(THR_W'($urandom_range(100, 1)));
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        send_random_words(90);
        settle();
    endtask

    // Receiver holds off for a long stretch while words keep coming, so the
    // output register and the pending result fill and the input stalls.
    task automatic test_output_backpressure();
        write_threshold(8'd100);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = hold_req + 1;
        send_random_words(30);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Receiver stall generator, with the counted long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got usage %0d led %0b",
                         $time, usage_percent, led_level);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (usage_percent !== want.pct)
                begin
                    $display("%0t: usage_percent mismatch, expected %0d, got %0d",
                             $time, want.pct, usage_percent);
                    error_count++;
                end
                if (led_level !== want.led)
                begin
                    $display("%0t: led_level mismatch, expected %0b, got %0b",
                             $time, want.led, led_level);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d words still expected", $time, pending_readings.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_threshold_levels();
        test_random_back_to_back();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_gaps();
        test_output_backpressure();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
